// ===== design/ptq_pkg.sv =====
`default_nettype none

package ptq_pkg;

   // Default sizing of the queue
   localparam int QUEUE_DEPTH_DEF     = 16;
   localparam int PRIORITY_LEVELS_DEF = 4;
   localparam int ID_BITS_DEF         = 8;

   // Fixed field widths of the channel words
   localparam int TASK_ID_W   = 8;
   localparam int PRIORITY_W  = 2;
   localparam int STATUS_W    = 2;
   localparam int OCCUPANCY_W = 5;

   // Request opcodes
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_POP    = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POPPED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic                  action;
      logic [TASK_ID_W-1:0]  task_id;
      logic [PRIORITY_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0]   out_task_id;
      logic [PRIORITY_W-1:0]  out_priority;
      logic [STATUS_W-1:0]    status;
      logic [OCCUPANCY_W-1:0] occupancy;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic do_insert;
      logic do_pop;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/ptq_cell.sv =====
`default_nettype none

module ptq_cell #(
   parameter int ID_BITS = 8,
   parameter int PRIO_W  = 2,
   parameter int CNT_W   = 5,
   parameter int INDEX   = 0
) (
   input  wire logic                   clock,
   input  wire ptq_pkg::cell_ctrl_type ctrl,
   input  wire logic [CNT_W-1:0]       count,
   input  wire logic [ID_BITS-1:0]     new_id,
   input  wire logic [PRIO_W-1:0]      new_prio,
   input  wire logic                   left_keep,
   input  wire logic [ID_BITS-1:0]     left_id,
   input  wire logic [PRIO_W-1:0]      left_prio,
   input  wire logic [ID_BITS-1:0]     right_id,
   input  wire logic [PRIO_W-1:0]      right_prio,
   output logic                        keep,
   output logic [ID_BITS-1:0]          id,
   output logic [PRIO_W-1:0]           prio
);
   import ptq_pkg::*;

   logic [ID_BITS-1:0] id_ff,   id_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic               occupied;

   // Entry holds a live word when its slot lies below the fill count
   assign occupied = CNT_W'(INDEX) < count;

   // Strictly higher priority entries stay put on insert
   assign keep = occupied && (prio_ff > new_prio);

   // Next entry: hold, take the new word, shift down from left, or up from right
   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctrl.do_insert) begin
         if (!keep) begin
            if (left_keep) begin
               id_in   = new_id;
               prio_in = new_prio;
            end else begin
               id_in   = left_id;
               prio_in = left_prio;
            end
         end
      end else if (ctrl.do_pop) begin
         id_in   = right_id;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign id   = id_ff;
   assign prio = prio_ff;

endmodule

`default_nettype wire

// ===== design/priority_task_queue_unit.sv =====
// Sorted priority queue of task handles, highest priority at the head.
// Request channel (req_valid/req_ready/req_data): a word either inserts a
// task id with a priority or pops the head entry. Among equal priorities
// the newest insert is served first. Response channel (rsp_valid/rsp_ready/
// rsp_data): exactly one word per request, in request order, carrying the
// popped id and priority (zero on insert or error), a status code and the
// occupancy after the request.
// The response is valid in the cycle after the request is accepted. One
// request is taken every cycle: all cells of the chain compare against
// the new priority in parallel and shift by one slot in the same cycle,
// and the single response register is refilled in the cycle it is drained.
// When the receiver stalls, the response register holds its word and
// req_ready drops until it is taken.
// Reset empties the queue (fill count to zero) and clears the response
// valid; entry storage is not cleared and needs no sweep.
`default_nettype none

module priority_task_queue_unit #(
   parameter int QUEUE_DEPTH     = ptq_pkg::QUEUE_DEPTH_DEF,
   parameter int PRIORITY_LEVELS = ptq_pkg::PRIORITY_LEVELS_DEF,
   parameter int ID_BITS         = ptq_pkg::ID_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ptq_pkg::rsp_type      rsp_data
);
   import ptq_pkg::*;

   localparam int PRIO_W = (PRIORITY_LEVELS > 2) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   cell_ctrl_type      ctrl;
   logic [ID_BITS-1:0] new_id;
   logic [PRIO_W-1:0]  new_prio;

   logic               cell_keep [QUEUE_DEPTH];
   logic [ID_BITS-1:0] cell_id   [QUEUE_DEPTH];
   logic [PRIO_W-1:0]  cell_prio [QUEUE_DEPTH];

   // Accept whenever the response slot is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign is_empty = count_ff == '0;

   // Clamp priority to the configured levels, keep the low id bits
   assign new_prio = ({30'd0, req_data.priority_req} > 32'(PRIORITY_LEVELS - 1)) ?
                     PRIO_W'(PRIORITY_LEVELS - 1) : PRIO_W'(req_data.priority_req);
   assign new_id   = ID_BITS'(req_data.task_id);

   assign ctrl.do_insert = accept && (req_data.action == ACTION_INSERT) && !is_full;
   assign ctrl.do_pop    = accept && (req_data.action == ACTION_POP) && !is_empty;

   // Chain of storage cells, head at index zero
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic               left_keep;
      logic [ID_BITS-1:0] left_id,   right_id;
      logic [PRIO_W-1:0]  left_prio, right_prio;

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_id   = '0;
         assign left_prio = '0;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_id   = cell_id[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_id   = '0;
         assign right_prio = '0;
      end else begin : g_mid
         assign right_id   = cell_id[i+1];
         assign right_prio = cell_prio[i+1];
      end

      ptq_cell #(
         .ID_BITS (ID_BITS),
         .PRIO_W  (PRIO_W),
         .CNT_W   (CNT_W),
         .INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .new_id     (new_id),
         .new_prio   (new_prio),
         .left_keep  (left_keep),
         .left_id    (left_id),
         .left_prio  (left_prio),
         .right_id   (right_id),
         .right_prio (right_prio),
         .keep       (cell_keep[i]),
         .id         (cell_id[i]),
         .prio       (cell_prio[i])
      );
   end

   // Fill count and response word
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_task_id = '0;
         rsp_in.out_priority = '0;
         if (req_data.action == ACTION_INSERT) begin
            if (is_full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               rsp_in.status = STATUS_INSERTED;
               count_in      = count_ff + CNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.status       = STATUS_POPPED;
               rsp_in.out_task_id  = TASK_ID_W'(cell_id[0]);
               rsp_in.out_priority = PRIORITY_W'(cell_prio[0]);
               count_in            = count_ff - CNT_W'(1);
            end
         end
         rsp_in.occupancy = OCCUPANCY_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sim/priority_task_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module priority_task_queue_unit_tb;
   import ptq_pkg::*;

   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_WORDS = 400;

   // Mirror of the sorted queue: predicts each response word and checks it
   class queue_mirror;
      logic [TASK_ID_W-1:0]  ids[QUEUE_DEPTH_DEF];
      logic [PRIORITY_W-1:0] prios[QUEUE_DEPTH_DEF];
      int      fill;
      rsp_type expected_words[$];
      int      errors, n_inserted, n_popped, n_empty, n_full, peak;

      function int pending();
         return expected_words.size();
      endfunction

      // Apply one accepted request to the mirror and queue its response
      function void note_request(req_type r);
         rsp_type               e;
         int                    pos;
         logic [PRIORITY_W-1:0] p;
         logic [TASK_ID_W-1:0]  id;
         e = '0;
         p = r.priority_req;
         if (p > PRIORITY_LEVELS_DEF - 1)
            p = PRIORITY_W'(PRIORITY_LEVELS_DEF - 1);
         id = r.task_id;
         for (int b = ID_BITS_DEF; b < TASK_ID_W; b++)
            id[b] = 1'b0;
         if (r.action == ACTION_INSERT) begin
            if (fill >= QUEUE_DEPTH_DEF) begin
               e.status = STATUS_FULL;
               n_full++;
            end else begin
               // new entry goes behind strictly higher priorities only
               pos = 0;
               while (pos < fill && prios[pos] > p)
                  pos++;
               for (int i = fill; i > pos; i--) begin
                  ids[i]   = ids[i-1];
                  prios[i] = prios[i-1];
               end
               ids[pos]   = id;
               prios[pos] = p;
               fill++;
               e.status = STATUS_INSERTED;
               n_inserted++;
            end
         end else begin
            if (fill == 0) begin
               e.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               e.out_task_id  = ids[0];
               e.out_priority = prios[0];
               for (int i = 1; i < fill; i++) begin
                  ids[i-1]   = ids[i];
                  prios[i-1] = prios[i];
               end
               fill--;
               e.status = STATUS_POPPED;
               n_popped++;
            end
         end
         e.occupancy = OCCUPANCY_W'(fill);
         if (fill > peak)
            peak = fill;
         expected_words.push_back(e);
      endfunction

      function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one accepted response word with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_words.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         e = expected_words.pop_front();
         compare_field("out_task_id", e.out_task_id, got.out_task_id);
         compare_field("out_priority", 8'(e.out_priority), 8'(got.out_priority));
         compare_field("status", 8'(e.status), 8'(got.status));
         compare_field("occupancy", 8'(e.occupancy), 8'(got.occupancy));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int idle_send_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int n_sent = 0;

   queue_mirror mirror = new();

   priority_task_queue_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Handshake monitor, sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            mirror.note_request(req_data);
         if (rsp_valid === 1'b1 && rsp_ready)
            mirror.check_response(rsp_data);
      end
   end

   // Receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one word, with an optional random gap first
   task automatic send_word(req_type w);
      while (idle_send_pct > 0 && $urandom_range(99) < idle_send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      n_sent++;
   endtask

   task automatic send_insert(logic [TASK_ID_W-1:0] id, logic [PRIORITY_W-1:0] p);
      req_type w;
      w = '{action: ACTION_INSERT, task_id: id, priority_req: p};
      send_word(w);
   endtask

   // pop ignores id and priority, so those carry random bits
   task automatic send_pop();
      req_type w;
      w = '{action: ACTION_POP, task_id: TASK_ID_W'($urandom_range(255)),
            priority_req: PRIORITY_W'($urandom_range(3))};
      send_word(w);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() > 0)
         @(posedge clock);
   endtask

   // Random traffic in bursts that lean toward filling, draining or neither
   task automatic run_phase(int send_pct, int stall, int n_words);
      int      left, mode, pop_pct, lo_p, hi_p;
      req_type w;
      idle_send_pct = send_pct;
      stall_pct     = stall;
      left = 0;
      mode = 0;
      lo_p = 0;
      hi_p = 3;
      for (int i = 0; i < n_words; i++) begin
         if (left == 0) begin
            left = $urandom_range(60, 20);
            mode = $urandom_range(2);
            lo_p = $urandom_range(3);
            hi_p = $urandom_range(3, lo_p);
         end
         left--;
         pop_pct = (mode == 0) ? 20 : (mode == 1) ? 80 : 50;
         w.action       = ($urandom_range(99) < pop_pct) ? ACTION_POP : ACTION_INSERT;
         w.task_id      = TASK_ID_W'($urandom_range(255));
         w.priority_req = PRIORITY_W'($urandom_range(hi_p, lo_p));
         send_word(w);
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pop, field extremes, ordering among equal priorities
      send_pop();
      send_insert(8'hFF, 2'd0);
      send_insert(8'h00, 2'd3);
      send_insert(8'hAA, 2'd1);
      send_insert(8'h55, 2'd2);
      send_insert(8'h01, 2'd2);
      send_insert(8'h02, 2'd2);
      send_insert(8'h03, 2'd2);
      repeat (8) send_pop();
      wait_drained();

      // Receiver holds off while inserts keep coming: input stalls, queue fills
      hold_requests <= hold_requests + 1;
      repeat (30) send_insert(TASK_ID_W'($urandom_range(255)), PRIORITY_W'($urandom_range(3)));
      wait_drained();
      repeat (17) send_pop();
      wait_drained();

      run_phase(0, 0, PHASE_WORDS);
      run_phase(76, 0, PHASE_WORDS);
      run_phase(0, 76, PHASE_WORDS);
      run_phase(12, 12, PHASE_WORDS);

      wait_drained();
      repeat (5) @(posedge clock);
      if (mirror.pending() > 0) begin
         $error("%0d expected response words never arrived", mirror.pending());
         mirror.errors++;
      end
      $display("Sent %0d requests: %0d inserted, %0d popped, %0d empty pops, %0d full drops",
               n_sent, mirror.n_inserted, mirror.n_popped, mirror.n_empty, mirror.n_full);
      $display("Peak occupancy %0d, one long receiver hold-off, four idle/stall mixes",
               mirror.peak);
      if (mirror.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
design/ptq_pkg.sv
design/ptq_cell.sv
design/priority_task_queue_unit.sv
sim/priority_task_queue_unit_tb.sv
